>>> rtl/core/jsu_pkg.sv
`default_nettype none
package jsu_pkg;

   localparam int LENGTH_BITS_DEFAULT = 32;
   localparam int REPORT_LEN_BITS     = 32;
   localparam int QUEUE_DEPTH         = 2;

   // what one queue entry asks the back end to send
   localparam logic [1:0] ENT_BYTES = 2'd0;
   localparam logic [1:0] ENT_DONE  = 2'd1;
   localparam logic [1:0] ENT_ERROR = 2'd2;

   typedef struct packed {
      logic [1:0]                 code;
      logic [1:0]                 count_m1;
      logic [3:0][7:0]            bytes;
      logic [REPORT_LEN_BITS-1:0] length;
      logic                       key;
   } entry_type;

   typedef struct packed {
      logic [1:0]      count_m1;
      logic [3:0][7:0] bytes;
   } utf8_type;

   // {ok, value}
   function automatic logic [4:0] decode_hex_char(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

   function automatic utf8_type encode_code_point(input logic [20:0] cp);
      utf8_type r;
      r = '0;
      if (cp[20:7] == '0) begin
         r.count_m1 = 2'd0;
         r.bytes[0] = {1'b0, cp[6:0]};
      end else if (cp[20:11] == '0) begin
         r.count_m1 = 2'd1;
         r.bytes[0] = {3'b110, cp[10:6]};
         r.bytes[1] = {2'b10, cp[5:0]};
      end else if (cp[20:16] == '0) begin
         r.count_m1 = 2'd2;
         r.bytes[0] = {4'b1110, cp[15:12]};
         r.bytes[1] = {2'b10, cp[11:6]};
         r.bytes[2] = {2'b10, cp[5:0]};
      end else begin
         r.count_m1 = 2'd3;
         r.bytes[0] = {5'b11110, cp[20:18]};
         r.bytes[1] = {2'b10, cp[17:12]};
         r.bytes[2] = {2'b10, cp[11:6]};
         r.bytes[3] = {2'b10, cp[5:0]};
      end
      return r;
   endfunction

endpackage
`default_nettype wire

>>> rtl/core/jsu_front.sv
`default_nettype none
module jsu_front #(
   parameter int LENGTH_BITS = jsu_pkg::LENGTH_BITS_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   input  wire logic [7:0]          in_byte,
   input  wire logic                in_end,
   input  wire logic                in_kind,
   output jsu_pkg::entry_type       push_entry,
   output logic                     push_valid
);
   import jsu_pkg::*;

   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_BODY    = 3'd1;
   localparam logic [2:0] PH_ESC     = 3'd2;
   localparam logic [2:0] PH_HEX1    = 3'd3;
   localparam logic [2:0] PH_WAIT_BS = 3'd4;
   localparam logic [2:0] PH_WAIT_U  = 3'd5;
   localparam logic [2:0] PH_HEX2    = 3'd6;

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_B      = 8'h62;
   localparam logic [7:0] CH_F      = 8'h66;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_U      = 8'h75;
   localparam logic [7:0] CH_SPACE  = 8'h20;

   logic [2:0]             phase_ff, phase_in;
   logic [15:0]            hex_accum_ff, hex_accum_in;
   logic [1:0]             hex_count_ff, hex_count_in;
   logic [9:0]             high_sur_ff, high_sur_in;
   logic [LENGTH_BITS-1:0] length_ff, length_in;
   logic                   kind_ff, kind_in;

   logic [4:0]             hex;
   logic [15:0]            acc_next;
   logic [10:0]            plane;
   utf8_type               enc;
   logic [LENGTH_BITS:0]   len_sum;

   assign hex      = decode_hex_char(in_byte);
   assign acc_next = {hex_accum_ff[11:0], hex[3:0]};
   // supplementary plane: 0x10000 + (high << 10) + low bits
   assign plane    = {1'b0, high_sur_ff} + 11'h040;
   assign enc      = encode_code_point((phase_ff == PH_HEX2) ? {plane[10:0], acc_next[9:0]}
                                                             : {5'd0, acc_next});

   always_comb begin
      phase_in     = phase_ff;
      hex_accum_in = hex_accum_ff;
      hex_count_in = hex_count_ff;
      high_sur_in  = high_sur_ff;
      length_in    = length_ff;
      kind_in      = kind_ff;
      push_valid   = 1'b0;
      push_entry   = '0;
      len_sum      = '0;

      if (in_valid) begin
         if (in_end) begin
            push_valid      = 1'b1;
            push_entry.code = ENT_ERROR;
         end else begin
            unique case (phase_ff) inside
               PH_IDLE: begin
                  if (in_byte == CH_QUOTE) begin
                     kind_in   = in_kind;
                     length_in = '0;
                     phase_in  = PH_BODY;
                  end else begin
                     push_valid      = 1'b1;
                     push_entry.code = ENT_ERROR;
                  end
               end
               PH_BODY: begin
                  if (in_byte == CH_QUOTE) begin
                     push_valid        = 1'b1;
                     push_entry.code   = ENT_DONE;
                     push_entry.length = REPORT_LEN_BITS'(length_ff);
                     push_entry.key    = kind_ff;
                     phase_in          = PH_IDLE;
                  end else if (in_byte == CH_BSLASH) begin
                     phase_in = PH_ESC;
                  end else if (in_byte < CH_SPACE) begin
                     push_valid      = 1'b1;
                     push_entry.code = ENT_ERROR;
                  end else begin
                     push_valid          = 1'b1;
                     push_entry.code     = ENT_BYTES;
                     push_entry.bytes[0] = in_byte;
                  end
               end
               PH_ESC: begin
                  push_valid      = 1'b1;
                  push_entry.code = ENT_BYTES;
                  unique case (in_byte) inside
                     CH_QUOTE, CH_BSLASH, CH_SLASH: push_entry.bytes[0] = in_byte;
                     CH_B: push_entry.bytes[0] = 8'h08;
                     CH_F: push_entry.bytes[0] = 8'h0C;
                     CH_N: push_entry.bytes[0] = 8'h0A;
                     CH_R: push_entry.bytes[0] = 8'h0D;
                     CH_T: push_entry.bytes[0] = 8'h09;
                     CH_U: begin
                        push_valid   = 1'b0;
                        hex_accum_in = '0;
                        hex_count_in = '0;
                        phase_in     = PH_HEX1;
                     end
                     default: push_entry.code = ENT_ERROR;
                  endcase
               end
               PH_HEX1, PH_HEX2: begin
                  if (!hex[4]) begin
                     push_valid      = 1'b1;
                     push_entry.code = ENT_ERROR;
                  end else if (hex_count_ff != 2'd3) begin
                     hex_accum_in = acc_next;
                     hex_count_in = hex_count_ff + 2'd1;
                  end else begin
                     hex_accum_in = acc_next;
                     hex_count_in = '0;
                     if (phase_ff == PH_HEX1 && acc_next[15:10] == 6'b110110) begin
                        high_sur_in = acc_next[9:0];
                        phase_in    = PH_WAIT_BS;
                     end else if ((phase_ff == PH_HEX1) == (acc_next[15:10] == 6'b110111)) begin
                        // lone low surrogate, or a pair whose second half is not low
                        push_valid      = 1'b1;
                        push_entry.code = ENT_ERROR;
                     end else begin
                        push_valid          = 1'b1;
                        push_entry.code     = ENT_BYTES;
                        push_entry.count_m1 = enc.count_m1;
                        push_entry.bytes    = enc.bytes;
                     end
                  end
               end
               PH_WAIT_BS: begin
                  if (in_byte == CH_BSLASH) begin
                     phase_in = PH_WAIT_U;
                  end else begin
                     push_valid      = 1'b1;
                     push_entry.code = ENT_ERROR;
                  end
               end
               PH_WAIT_U: begin
                  if (in_byte == CH_U) begin
                     hex_accum_in = '0;
                     hex_count_in = '0;
                     phase_in     = PH_HEX2;
                  end else begin
                     push_valid      = 1'b1;
                     push_entry.code = ENT_ERROR;
                  end
               end
               default: begin
                  push_valid      = 1'b1;
                  push_entry.code = ENT_ERROR;
               end
            endcase
         end

         if (push_valid && push_entry.code == ENT_BYTES) begin
            len_sum   = {1'b0, length_ff}
                      + (LENGTH_BITS+1)'({1'b0, push_entry.count_m1} + 3'd1);
            phase_in  = PH_BODY;
            length_in = len_sum[LENGTH_BITS] ? '1 : len_sum[LENGTH_BITS-1:0];
         end else if (push_valid && push_entry.code == ENT_ERROR) begin
            phase_in     = PH_IDLE;
            hex_accum_in = '0;
            hex_count_in = '0;
            high_sur_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         hex_accum_ff <= '0;
         hex_count_ff <= '0;
         high_sur_ff  <= '0;
         length_ff    <= '0;
         kind_ff      <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         hex_accum_ff <= hex_accum_in;
         hex_count_ff <= hex_count_in;
         high_sur_ff  <= high_sur_in;
         length_ff    <= length_in;
         kind_ff      <= kind_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/core/jsu_queue.sv
`default_nettype none
module jsu_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  jsu_pkg::entry_type      push_entry,
   output logic                    full,
   output logic                    head_valid,
   output jsu_pkg::entry_type      head_entry,
   input  wire logic               pop
);
   import jsu_pkg::*;

   localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   entry_type             slots_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  do_push, do_pop;

   assign full       = (count_ff == CNT_BITS'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slots_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

>>> rtl/core/jsu_back.sv
`default_nettype none
module jsu_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               head_valid,
   input  jsu_pkg::entry_type      head_entry,
   output logic                    pop,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [39:0]             rsp_tdata,
   output logic [3:0]              rsp_tuser,
   output logic                    rsp_tlast
);
   import jsu_pkg::*;

   logic [1:0]  idx_ff, idx_in;
   logic        valid_ff, valid_in;
   logic [39:0] data_ff;
   logic [3:0]  user_ff;
   logic        last_ff;
   logic        load;
   logic        is_last;
   logic        is_bytes, is_done;

   assign load     = head_valid && (!valid_ff || rsp_tready);
   assign is_last  = (idx_ff == head_entry.count_m1);
   assign pop      = load && is_last;
   assign is_bytes = (head_entry.code == ENT_BYTES);
   assign is_done  = (head_entry.code == ENT_DONE);

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (rsp_tready) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
         idx_in   = is_last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= {is_done ? head_entry.length : '0,
                     is_bytes ? head_entry.bytes[idx_ff] : 8'd0};
         user_ff <= {head_entry.code == ENT_ERROR, is_done && head_entry.key,
                     is_done, is_bytes};
         last_ff <= is_last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;
   assign rsp_tlast  = last_ff;

endmodule
`default_nettype wire

>>> rtl/core/json_string_unescape_utf8_unit.sv
// JSON string unescaper: takes the source text of one quoted string a byte per transfer,
// opening quote first, and sends the decoded UTF-8 bytes, then one result with the decoded
// length and string kind at the closing quote, or one parse error result that returns the
// block to idle. An input byte is taken whenever the two-entry queue has room; a front
// parser classifies it and queues at most one entry, and a back end sends that entry's
// results one per cycle while the result side accepts them, through the queue slot and
// then an output register. Most bytes cause one result, so the sustained rate is one byte
// per cycle; a \u escape that gives k result bytes (up to four) sends them one per cycle
// and can hold the input meanwhile, and it always follows at least five bytes that send
// nothing. The input also waits while the result side stalls and the queue is full.
`default_nettype none
module json_string_unescape_utf8_unit #(
   parameter int LENGTH_BITS = jsu_pkg::LENGTH_BITS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // text_byte
   input  wire logic        req_tlast,   // text_end
   input  wire logic        req_tuser,   // string_kind
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // out_byte[7:0], decoded_length[39:8]
   output logic [3:0]       rsp_tuser,   // byte_valid, string_done, kind_out, parse_error
   output logic             rsp_tlast    // last
);
   import jsu_pkg::*;

   entry_type push_entry, head_entry;
   logic      push_valid, full, head_valid, pop;

   assign req_tready = !full;

   jsu_front #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid && !full),
      .in_byte    (req_tdata),
      .in_end     (req_tlast),
      .in_kind    (req_tuser),
      .push_entry (push_entry),
      .push_valid (push_valid)
   );

   jsu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_entry (push_entry),
      .full       (full),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop)
   );

   jsu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire
